### rtl/i2cbe_pkg.sv
package i2cbe_pkg;

  // operation codes carried in s_tuser
  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_WAIT  = 3'd4,
    OP_TICK  = 3'd5
  } op_t;

  // command sequencer state, one-hot
  typedef enum logic [5:0] {
    CMD_IDLE  = 6'b000001,
    CMD_START = 6'b000010,
    CMD_STOP  = 6'b000100,
    CMD_WRITE = 6'b001000,
    CMD_READ  = 6'b010000,
    CMD_WAIT  = 6'b100000
  } cmd_t;

  localparam logic [2:0] EDGE_HOLD        = 3'd4;
  localparam logic [2:0] BIT_HOLD         = 3'd2;
  localparam logic [3:0] BYTE_BITS        = 4'd8;
  localparam logic [7:0] POLL_LIMIT_RESET = 8'd250;

  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] phase;
    logic [3:0] bit_count;
    logic [2:0] hold;
    logic [7:0] poll;
    logic [7:0] shreg;
    logic [1:0] amode;
    logic       scl;
    logic       sda;
    logic       drv;
    logic       err;
    logic [7:0] rdata;
  } state_t;

  localparam state_t STATE_RESET = '{
    cmd:       CMD_IDLE,
    phase:     2'd0,
    bit_count: 4'd0,
    hold:      3'd0,
    poll:      8'd0,
    shreg:     8'd0,
    amode:     2'd0,
    scl:       1'b1,
    sda:       1'b1,
    drv:       1'b1,
    err:       1'b0,
    rdata:     8'd0
  };

  typedef struct packed {
    logic done;
    logic rejected;
  } flags_t;

endpackage

### rtl/i2cbe_step.sv
module i2cbe_step (
  input  i2cbe_pkg::state_t st,
  input  logic [2:0]        op,
  input  logic [7:0]        wdata,
  input  logic [1:0]        amode,
  input  logic              sda,
  input  logic [7:0]        limit,
  output i2cbe_pkg::state_t nxt,
  output i2cbe_pkg::flags_t flags
);

  logic       busy;
  logic [2:0] hold_dec;
  logic [3:0] bc_inc;
  logic [7:0] rd_shift;

  assign busy     = st.cmd != i2cbe_pkg::CMD_IDLE;
  assign hold_dec = (st.hold != 3'd0) ? st.hold - 3'd1 : 3'd0;
  assign bc_inc   = st.bit_count + 4'd1;
  assign rd_shift = {st.shreg[6:0], sda};

  always_comb begin
    nxt            = st;
    flags.done     = 1'b0;
    flags.rejected = 1'b0;
    unique case (op)
      i2cbe_pkg::OP_START, i2cbe_pkg::OP_STOP, i2cbe_pkg::OP_WRITE,
      i2cbe_pkg::OP_READ, i2cbe_pkg::OP_WAIT: begin
        if (busy) begin
          flags.rejected = 1'b1;
        end else begin
          nxt.phase = 2'd0;
          unique case (op)
            i2cbe_pkg::OP_START: begin
              nxt.cmd  = i2cbe_pkg::CMD_START;
              nxt.drv  = 1'b1;
              nxt.sda  = 1'b1;
              nxt.scl  = 1'b1;
              nxt.hold = i2cbe_pkg::EDGE_HOLD;
            end
            i2cbe_pkg::OP_STOP: begin
              nxt.cmd  = i2cbe_pkg::CMD_STOP;
              nxt.drv  = 1'b1;
              nxt.scl  = 1'b0;
              nxt.sda  = 1'b0;
              nxt.hold = i2cbe_pkg::EDGE_HOLD;
            end
            i2cbe_pkg::OP_WRITE: begin
              nxt.cmd       = i2cbe_pkg::CMD_WRITE;
              nxt.drv       = 1'b1;
              nxt.scl       = 1'b0;
              nxt.bit_count = 4'd0;
              nxt.sda       = wdata[7];
              nxt.shreg     = {wdata[6:0], 1'b0};
              nxt.hold      = i2cbe_pkg::BIT_HOLD;
            end
            i2cbe_pkg::OP_READ: begin
              nxt.cmd       = i2cbe_pkg::CMD_READ;
              nxt.drv       = 1'b0;
              nxt.scl       = 1'b0;
              nxt.bit_count = 4'd0;
              nxt.shreg     = 8'd0;
              nxt.amode     = amode;
              nxt.hold      = i2cbe_pkg::BIT_HOLD;
            end
            default: begin
              nxt.cmd  = i2cbe_pkg::CMD_WAIT;
              nxt.drv  = 1'b0;
              nxt.sda  = 1'b1;
              nxt.poll = 8'd0;
              nxt.err  = 1'b0;
              nxt.hold = 3'd1;
            end
          endcase
        end
      end
      i2cbe_pkg::OP_TICK: begin
        if (busy) begin
          if (st.cmd == i2cbe_pkg::CMD_WAIT && st.phase == 2'd2) begin
            // ack poll, one sample a tick
            nxt.phase = 2'd2;
            nxt.hold  = 3'd0;
            if (!sda) begin
              nxt.scl    = 1'b0;
              nxt.err    = 1'b0;
              nxt.cmd    = i2cbe_pkg::CMD_IDLE;
              nxt.phase  = 2'd0;
              flags.done = 1'b1;
            end else if (st.poll >= limit) begin
              // timeout: flag and fall into a stop sequence
              nxt.err   = 1'b1;
              nxt.cmd   = i2cbe_pkg::CMD_STOP;
              nxt.drv   = 1'b1;
              nxt.scl   = 1'b0;
              nxt.sda   = 1'b0;
              nxt.phase = 2'd0;
              nxt.hold  = i2cbe_pkg::EDGE_HOLD;
            end else begin
              nxt.poll = st.poll + 8'd1;
            end
          end else begin
            nxt.hold = hold_dec;
            if (hold_dec == 3'd0) begin
              unique case (st.cmd)
                i2cbe_pkg::CMD_START: begin
                  if (st.phase == 2'd0) begin
                    nxt.sda   = 1'b0;
                    nxt.phase = 2'd1;
                    nxt.hold  = i2cbe_pkg::EDGE_HOLD;
                  end else begin
                    nxt.scl    = 1'b0;
                    nxt.cmd    = i2cbe_pkg::CMD_IDLE;
                    nxt.phase  = 2'd0;
                    flags.done = 1'b1;
                  end
                end
                i2cbe_pkg::CMD_STOP: begin
                  if (st.phase == 2'd0) begin
                    nxt.scl   = 1'b1;
                    nxt.phase = 2'd1;
                    nxt.hold  = i2cbe_pkg::EDGE_HOLD;
                  end else begin
                    nxt.sda    = 1'b1;
                    nxt.cmd    = i2cbe_pkg::CMD_IDLE;
                    nxt.phase  = 2'd0;
                    flags.done = 1'b1;
                  end
                end
                i2cbe_pkg::CMD_WRITE: begin
                  if (st.phase == 2'd0) begin
                    nxt.scl   = 1'b1;
                    nxt.phase = 2'd1;
                    nxt.hold  = i2cbe_pkg::BIT_HOLD;
                  end else if (st.phase == 2'd1) begin
                    nxt.scl   = 1'b0;
                    nxt.phase = 2'd2;
                    nxt.hold  = i2cbe_pkg::BIT_HOLD;
                  end else begin
                    nxt.bit_count = bc_inc;
                    if (bc_inc >= i2cbe_pkg::BYTE_BITS) begin
                      nxt.cmd    = i2cbe_pkg::CMD_IDLE;
                      nxt.phase  = 2'd0;
                      flags.done = 1'b1;
                    end else begin
                      nxt.sda   = st.shreg[7];
                      nxt.shreg = {st.shreg[6:0], 1'b0};
                      nxt.phase = 2'd0;
                      nxt.hold  = i2cbe_pkg::BIT_HOLD;
                    end
                  end
                end
                i2cbe_pkg::CMD_READ: begin
                  if (st.phase == 2'd0) begin
                    // scl rises, sample into the lsb
                    nxt.scl       = 1'b1;
                    nxt.shreg     = rd_shift;
                    nxt.bit_count = bc_inc;
                    if (bc_inc >= i2cbe_pkg::BYTE_BITS) nxt.rdata = rd_shift;
                    nxt.phase = 2'd1;
                    nxt.hold  = 3'd1;
                  end else if (st.phase == 2'd1) begin
                    if (st.bit_count < i2cbe_pkg::BYTE_BITS) begin
                      nxt.scl   = 1'b0;
                      nxt.phase = 2'd0;
                      nxt.hold  = i2cbe_pkg::BIT_HOLD;
                    end else if (st.amode > 2'd1) begin
                      // no ack bit, scl left high
                      nxt.cmd    = i2cbe_pkg::CMD_IDLE;
                      nxt.phase  = 2'd0;
                      flags.done = 1'b1;
                    end else begin
                      nxt.scl   = 1'b0;
                      nxt.drv   = 1'b1;
                      nxt.sda   = st.amode == 2'd0;
                      nxt.phase = 2'd2;
                      nxt.hold  = i2cbe_pkg::BIT_HOLD;
                    end
                  end else if (st.phase == 2'd2) begin
                    nxt.scl   = 1'b1;
                    nxt.phase = 2'd3;
                    nxt.hold  = i2cbe_pkg::BIT_HOLD;
                  end else begin
                    nxt.scl    = 1'b0;
                    nxt.cmd    = i2cbe_pkg::CMD_IDLE;
                    nxt.phase  = 2'd0;
                    flags.done = 1'b1;
                  end
                end
                i2cbe_pkg::CMD_WAIT: begin
                  // only phases 0 and 1 get here, phase 2 polling is handled above
                  nxt.scl   = 1'b1;
                  nxt.phase = 2'd2;
                  nxt.hold  = 3'd0;
                  if (st.phase == 2'd0) begin
                    nxt.phase = 2'd1;
                    nxt.hold  = 3'd1;
                  end
                  if (st.phase != 2'd0) begin
                    nxt.scl = st.scl;
                    if (!sda) begin
                      nxt.scl    = 1'b0;
                      nxt.err    = 1'b0;
                      nxt.cmd    = i2cbe_pkg::CMD_IDLE;
                      nxt.phase  = 2'd0;
                      flags.done = 1'b1;
                    end else if (st.poll >= limit) begin
                      nxt.err   = 1'b1;
                      nxt.cmd   = i2cbe_pkg::CMD_STOP;
                      nxt.drv   = 1'b1;
                      nxt.scl   = 1'b0;
                      nxt.sda   = 1'b0;
                      nxt.phase = 2'd0;
                      nxt.hold  = i2cbe_pkg::EDGE_HOLD;
                    end else begin
                      nxt.poll = st.poll + 8'd1;
                    end
                  end
                end
                default: begin
                  nxt.cmd    = i2cbe_pkg::CMD_IDLE;
                  nxt.phase  = 2'd0;
                  nxt.hold   = 3'd0;
                  flags.done = 1'b1;
                end
              endcase
            end
          end
        end
      end
      default: begin
        // unused operation codes leave everything alone
      end
    endcase
  end

endmodule

### rtl/i2c_master_bit_engine_core.sv
// channel  | fields (lsb first)                               | beat accepted when
// ---------+--------------------------------------------------+-----------------------
// s_       | tuser: operation; tdata: write_data, ack_mode,   | s_tvalid && s_tready
//          |   sda_in                                         |
// m_       | tdata: scl, sda_out, sda_drive, busy_res,        | m_tvalid && m_tready
//          |   done_res, read_data, ack_error, rejected       |
// cfg_     | ack_poll_limit                                   | cfg_we
//
// one beat in, one beat out; the sequencer update is combinational logic
// between the state registers and the result register, so one beat a cycle while the output is not stalled.
// the result is registered and appears in the cycle after its input beat is taken.
// rst (synchronous) returns the sequencer to idle with both lines high and driven.
// a stalled output holds its beat; a new input is taken only when the output
// register is empty or being drained in the same cycle.
module i2c_master_bit_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // write_data[7:0], ack_mode[9:8], sda_in[10], zero fill
  input  logic [2:0]  s_tuser,   // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl[0], sda_out[1], sda_drive[2], busy_res[3],
                                 // done_res[4], read_data[12:5], ack_error[13],
                                 // rejected[14], zero fill
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  i2cbe_pkg::state_t state;
  i2cbe_pkg::state_t state_next;
  i2cbe_pkg::flags_t flags;
  logic [7:0]        ack_poll_limit;
  logic              accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  i2cbe_step u_step (
    .st    (state),
    .op    (s_tuser),
    .wdata (s_tdata[7:0]),
    .amode (s_tdata[9:8]),
    .sda   (s_tdata[10]),
    .limit (ack_poll_limit),
    .nxt   (state_next),
    .flags (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= i2cbe_pkg::STATE_RESET;
      ack_poll_limit <= i2cbe_pkg::POLL_LIMIT_RESET;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) ack_poll_limit <= cfg_wdata;
      if (accept) begin
        state    <= state_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0, flags.rejected, state_next.err, state_next.rdata, flags.done,
                  state_next.cmd != i2cbe_pkg::CMD_IDLE, state_next.drv,
                  state_next.sda, state_next.scl};
    end
  end

endmodule

### rtl/i2cbe_checker.sv
module i2cbe_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a rejected command never changes the state, so the engine still reports busy
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[14] |-> m_tdata[3])
    else $error("rejected beat without busy");

  // a finished command leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> !m_tdata[3])
    else $error("done beat while busy");

  // an idle engine always leaves scl as driven by the last sequence and never errs
  // without having polled: ack_error can only rise on a busy beat
  a_err_rise_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13] && $past(m_tvalid) && !$past(m_tdata[13]) |-> m_tdata[3])
    else $error("ack error raised outside a sequence");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

endmodule

bind i2c_master_bit_engine_core i2cbe_checker u_checker (.*);
